@@ sv/gge_pkg.sv @@
package gge_pkg;

  localparam int BLOCK_MAX = 64;
  localparam int LEN_W = 7;
  localparam int NUM_CFG = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ATT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_REL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ATT_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_REL_A = 3'd6;

  localparam logic [31:0] CFG_RESET [NUM_CFG] = '{
    32'd1047904911, 32'd1051260355, 32'd1065353216, 32'd1065350183,
    32'd984498811, 32'd1065353216, 32'd1065351699, 32'd1065351699
  };

  localparam logic [31:0] F_SNAP = 32'h3780_0000;
  localparam logic [31:0] F_SNAP_NEG = 32'hB780_0000;
  localparam logic [31:0] F_SMALL = 32'h3C80_0000;
  localparam logic [31:0] F_SMALL_NEG = 32'hBC80_0000;
  localparam logic [31:0] F_STEP = 32'h3C00_0000;
  localparam logic [31:0] F_SPAN = 32'h4300_0000;
  localparam logic [31:0] F_TINY = 32'h3400_0000;
  localparam logic [31:0] F_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F_QUIET = 32'h0040_0000;
  localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  typedef logic [NUM_CFG-1:0][31:0] cfg_t;

  typedef struct packed {
    logic             band;
    logic             start;
    logic             fin;
    logic [LEN_W-1:0] len;
    logic [31:0]      target;
    logic [31:0]      detect;
    logic [31:0]      left;
    logic [31:0]      right;
  } item_t;

  typedef enum logic [1:0] {FP_ADD, FP_SUB, FP_MUL} fp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_CLS, S_INC, S_SPAN, S_RSET, S_CUR, S_THR,
    S_PSUB, S_PMUL, S_PADD, S_PREL, S_GSEL, S_GSUM, S_GPROD, S_GSUB,
    S_GREL, S_LEFT, S_RIGHT, S_DONE
  } seq_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] flush(input logic [31:0] x);
    return ((x & EXP_MASK) == 32'd0) ? (x & SIGN_MASK) : x;
  endfunction

  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : (a | SIGN_MASK);
    kb = b[31] ? ~b : (b | SIGN_MASK);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    return ka < kb;
  endfunction

  // Value is m / 2^47 * 2^(e - 127); round to nearest even.
  function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                           input logic [47:0] m);
    logic [5:0] lz;
    logic [47:0] mn;
    logic signed [11:0] en;
    logic signed [11:0] rsh;
    logic [47:0] m2;
    logic st;
    logic [7:0] ef;
    logic up;
    logic [30:0] mag;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) lz = 6'(47 - i);
    end
    mn = m << lz;
    en = e - $signed({6'd0, lz});
    rsh = 12'sd1 - en;
    st = 1'b0;
    if (en >= 12'sd1) begin
      m2 = mn;
      ef = en[7:0];
    end else begin
      ef = 8'd0;
      if (rsh >= 12'sd48) begin
        m2 = 48'd0;
        st = |mn;
      end else begin
        m2 = mn >> rsh[5:0];
        st = |(mn & ((48'd1 << rsh[5:0]) - 48'd1));
      end
    end
    if (m == 48'd0) return {s, 31'd0};
    if (en >= 12'sd255) return {s, 8'hFF, 23'd0};
    up = m2[23] & ((|m2[22:0]) | st | m2[24]);
    mag = {ef, m2[46:24]} + {30'd0, up};
    return {s, mag};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    logic a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0] ea, eb;
    logic signed [11:0] e;
    s = a[31] ^ b[31];
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = a[30:0] == 31'd0;
    b_zero = b[30:0] == 31'd0;
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
    if (is_nan(a)) return a | F_QUIET;
    if (is_nan(b)) return b | F_QUIET;
    if ((a_inf && b_zero) || (a_zero && b_inf)) return F_DEFAULT_NAN;
    if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
    if (a_zero || b_zero) return {s, 31'd0};
    return fp_round(s, e, ma * mb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic a_inf, b_inf;
    logic [31:0] big, sml;
    logic [7:0] eg, es, diff;
    logic [47:0] xb, xs0, xs, m;
    logic st;
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff = eg - es;
    xb = {1'b0, big[30:23] != 8'd0, big[22:0], 23'd0};
    xs0 = {1'b0, sml[30:23] != 8'd0, sml[22:0], 23'd0};
    if (diff >= 8'd48) begin
      xs = 48'd0;
      st = |xs0;
    end else begin
      xs = xs0 >> diff[5:0];
      st = |(xs0 & ((48'd1 << diff[5:0]) - 48'd1));
    end
    xs[0] = xs[0] | st;
    m = (a[31] == b[31]) ? (xb + xs) : (xb - xs);
    if (is_nan(a)) return a | F_QUIET;
    if (is_nan(b)) return b | F_QUIET;
    if (a_inf && b_inf && (a[31] != b[31])) return F_DEFAULT_NAN;
    if (a_inf) return a;
    if (b_inf) return b;
    if (m == 48'd0) return {a[31] & b[31], 31'd0};
    return fp_round(big[31], $signed({4'd0, eg}) + 12'sd1, m);
  endfunction

  function automatic logic [31:0] len_to_float(input logic [LEN_W-1:0] n);
    logic [2:0] msb;
    logic [22:0] frac;
    msb = 3'd0;
    for (int i = 0; i < LEN_W; i++) begin
      if (n[i]) msb = 3'(i);
    end
    frac = 23'({16'd0, n} << (5'd23 - {2'd0, msb}));
    if (n == '0) return 32'd0;
    return {1'b0, 8'd127 + {5'd0, msb}, frac};
  endfunction

endpackage

@@ sv/gated_gain_envelope_top.sv @@
// Channel  | Handshake                   | Payload
// sample   | sample_valid / sample_stall | band, block_start, block_end, block_length,
//          |                             | target_level, detect_level, left_in, right_in
// result   | result_valid / result_stall | left_out, right_out
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A beat's path after it leaves the input queue is set by the peak and gain branches;
// block start adds S_DIFF and S_CLS, plus S_INC, S_SPAN and S_RSET when a new ramp is set up.
// S_IDLE lies between items; one shared float add/multiply unit works per cycle.
// A two-entry input queue takes new beats while the back end works.
// Reset is synchronous and restores all follower state and register defaults.
// A stalled result holds the finished beat; the queue keeps filling until full.
module gated_gain_envelope_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic                          band,
  input  logic                          block_start,
  input  logic                          block_end,
  input  logic [gge_pkg::LEN_W-1:0]     block_length,
  input  logic [31:0]                   target_level,
  input  logic [31:0]                   detect_level,
  input  logic [31:0]                   left_in,
  input  logic [31:0]                   right_in,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [31:0]                   left_out,
  output logic [31:0]                   right_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import gge_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg[i] <= CFG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  gge_front u_front (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .band(band), .block_start(block_start), .block_end(block_end),
    .block_length(block_length), .target_level(target_level),
    .detect_level(detect_level), .left_in(left_in), .right_in(right_in),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  gge_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .result_valid(result_valid), .result_stall(result_stall),
    .left_out(left_out), .right_out(right_out)
  );

endmodule

@@ sv/gge_fpu.sv @@
module gge_fpu (
  input  gge_pkg::fp_op_t op,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output logic [31:0]     res
);
  import gge_pkg::*;

  logic [31:0] b_neg;

  assign b_neg = is_nan(b) ? b : (b ^ SIGN_MASK);

  always_comb begin
    case (op)
      FP_ADD: res = fp_add(a, b);
      FP_SUB: res = fp_add(a, b_neg);
      FP_MUL: res = fp_mul(a, b);
      default: res = fp_add(a, b);
    endcase
  end

endmodule

@@ sv/gge_front.sv @@
module gge_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic                      band,
  input  logic                      block_start,
  input  logic                      block_end,
  input  logic [gge_pkg::LEN_W-1:0] block_length,
  input  logic [31:0]               target_level,
  input  logic [31:0]               detect_level,
  input  logic [31:0]               left_in,
  input  logic [31:0]               right_in,
  output logic                      q_valid,
  output gge_pkg::item_t            q_item,
  input  logic                      q_pop
);
  import gge_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      incoming;

  assign sample_stall = count == 2'd2;
  assign push = sample_valid && !sample_stall;
  assign q_valid = count != 2'd0;
  assign q_item = slots[rd_ptr];

  always_comb begin
    incoming.band = band;
    incoming.start = block_start;
    incoming.fin = block_end;
    incoming.len = (block_length > LEN_W'(BLOCK_MAX)) ? LEN_W'(BLOCK_MAX) : block_length;
    incoming.target = target_level;
    incoming.detect = detect_level;
    incoming.left = left_in;
    incoming.right = right_in;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ sv/gge_back.sv @@
module gge_back (
  input  logic           clk,
  input  logic           rst,
  input  gge_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  gge_pkg::item_t q_item,
  output logic           q_pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [31:0]    left_out,
  output logic [31:0]    right_out
);
  import gge_pkg::*;

  seq_t        state;
  seq_t        state_next;
  item_t       it;
  fp_op_t      op;
  logic [31:0] fa;
  logic [31:0] fb;
  logic [31:0] res;
  logic [31:0] ramp_value [2];
  logic [31:0] ramp_increment [2];
  logic [31:0] peak_follower [2];
  logic [31:0] gain_follower [2];
  logic [31:0] ramp_counter;
  logic [31:0] dlt;
  logic [31:0] tmp;
  logic [31:0] tmp2;
  logic [31:0] cur;
  logic [31:0] thr;
  logic [31:0] pk;
  logic [31:0] gn;
  logic        fine_step;
  logic        snap;
  logic        go_out;
  logic [31:0] ratio;
  logic [31:0] g_att;
  logic [31:0] g_rel;

  gge_fpu u_fpu (.op(op), .a(fa), .b(fb), .res(res));

  assign ratio = cfg[CFG_RATIO_A + {2'd0, it.band}];
  assign g_att = cfg[CFG_GAIN_ATT_A + {2'd0, it.band}];
  assign g_rel = cfg[CFG_GAIN_REL_A + {2'd0, it.band}];
  assign snap = fp_lt(dlt, F_SNAP) && fp_lt(F_SNAP_NEG, dlt);
  assign go_out = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = FP_ADD;
    fa = 32'd0;
    fb = 32'd0;
    q_pop = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = q_item.start ? S_DIFF : S_CUR;
        end
      end
      S_DIFF: begin
        op = FP_SUB;
        fa = it.target;
        fb = ramp_value[it.band];
        state_next = S_CLS;
      end
      S_CLS: begin
        state_next = (snap || (ramp_counter != 32'd0)) ? S_CUR : S_INC;
      end
      S_INC: begin
        op = FP_MUL;
        fa = dlt;
        fb = fine_step ? F_SMALL : F_STEP;
        state_next = S_SPAN;
      end
      S_SPAN: begin
        op = FP_MUL;
        fa = ramp_increment[it.band];
        fb = fine_step ? len_to_float(it.len) : F_SPAN;
        state_next = S_RSET;
      end
      S_RSET: begin
        op = FP_SUB;
        fa = it.target;
        fb = tmp;
        state_next = S_CUR;
      end
      S_CUR: begin
        fa = ramp_value[it.band];
        fb = ramp_increment[it.band];
        state_next = S_THR;
      end
      S_THR: begin
        op = FP_MUL;
        fa = cur;
        fb = ratio;
        state_next = fp_lt(peak_follower[it.band], it.detect) ? S_PSUB : S_PREL;
      end
      S_PSUB: begin
        op = FP_SUB;
        fa = it.detect;
        fb = peak_follower[it.band];
        state_next = S_PMUL;
      end
      S_PMUL: begin
        op = FP_MUL;
        fa = tmp;
        fb = cfg[CFG_PEAK_ATT];
        state_next = S_PADD;
      end
      S_PADD: begin
        fa = peak_follower[it.band];
        fb = tmp;
        state_next = S_GSEL;
      end
      S_PREL: begin
        op = FP_MUL;
        fa = peak_follower[it.band];
        fb = cfg[CFG_PEAK_REL];
        state_next = S_GSEL;
      end
      S_GSEL: begin
        state_next = fp_lt(thr, pk) ? S_GSUM : S_GREL;
      end
      S_GSUM: begin
        fa = g_att;
        fb = gain_follower[it.band];
        state_next = S_GPROD;
      end
      S_GPROD: begin
        op = FP_MUL;
        fa = gain_follower[it.band];
        fb = g_att;
        state_next = S_GSUB;
      end
      S_GSUB: begin
        op = FP_SUB;
        fa = tmp;
        fb = tmp2;
        state_next = S_LEFT;
      end
      S_GREL: begin
        op = FP_MUL;
        fa = gain_follower[it.band];
        fb = g_rel;
        state_next = S_LEFT;
      end
      S_LEFT: begin
        op = FP_MUL;
        fa = flush(it.left);
        fb = flush(gn);
        state_next = S_RIGHT;
      end
      S_RIGHT: begin
        op = FP_MUL;
        fa = flush(it.right);
        fb = flush(gn);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (go_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        ramp_value[i] <= 32'd0;
        ramp_increment[i] <= 32'd0;
        peak_follower[i] <= 32'd0;
        gain_follower[i] <= 32'd0;
      end
      ramp_counter <= 32'd0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      case (state)
        S_CLS: begin
          if (snap) begin
            ramp_counter <= 32'd0;
            ramp_increment[it.band] <= 32'd0;
            ramp_value[it.band] <= it.target;
          end else if (ramp_counter != 32'd0) begin
            ramp_counter <= ramp_counter + {25'd0, it.len};
          end
        end
        S_INC: ramp_increment[it.band] <= res;
        S_RSET: begin
          ramp_value[it.band] <= res;
          ramp_counter <= {25'd0, it.len};
        end
        S_CUR: ramp_value[it.band] <= res;
        S_DONE: begin
          if (go_out) begin
            peak_follower[it.band] <= (it.fin && fp_lt(pk, F_TINY)) ? 32'd0 : pk;
            gain_follower[it.band] <= (it.fin && fp_lt(gn, F_TINY)) ? 32'd0 : gn;
            result_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (q_pop) it <= q_item;
      S_DIFF: dlt <= res;
      S_CLS: fine_step <= fp_lt(dlt, F_SMALL) && fp_lt(F_SMALL_NEG, dlt);
      S_SPAN, S_PSUB, S_PMUL, S_GSUM: tmp <= res;
      S_RSET: tmp <= res;
      S_CUR: cur <= res;
      S_THR: thr <= res;
      S_PADD, S_PREL: pk <= res;
      S_GPROD: tmp2 <= res;
      S_GSUB, S_GREL: gn <= res;
      S_LEFT: tmp <= flush(res);
      S_RIGHT: tmp2 <= flush(res);
      S_DONE: begin
        if (go_out) begin
          left_out <= tmp;
          right_out <= tmp2;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE && q_valid))
    else $error("queue popped outside idle");

  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLS && state != S_RSET) |=> $stable(ramp_counter))
    else $error("ramp counter changed outside set-up");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised without a finished item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && result_valid && result_stall) |=> state == S_DONE)
    else $error("finished item left while output beat stalled");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import gge_pkg::*;

  localparam logic [31:0] QNAN_BIT = 32'h0040_0000;
  localparam logic [31:0] ONE = 32'h3F80_0000;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } pair_t;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  logic band;
  logic block_start;
  logic block_end;
  logic [LEN_W-1:0] block_length;
  logic [31:0] target_level;
  logic [31:0] detect_level;
  logic [31:0] left_in;
  logic [31:0] right_in;
  logic result_valid;
  logic result_stall;
  logic [31:0] left_out;
  logic [31:0] right_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] gate_cfg [NUM_CFG];
  logic [31:0] ramp_lvl [2];
  logic [31:0] ramp_step [2];
  logic [31:0] peak_lvl [2];
  logic [31:0] gain_lvl [2];
  logic [31:0] shared_count;
  pair_t gated_q [$];
  bit failed;
  bit steady;

  gated_gain_envelope_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic fnan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic real pow2(input int k);
    logic [10:0] eb;
    eb = 11'(k + 1023);
    return $bitstoreal({1'b0, eb, 52'd0});
  endfunction

  function automatic real to_real(input logic [31:0] f);
    int e;
    real mag;
    if (f[30:23] == 8'hFF) return $bitstoreal({f[31], 11'h7FF, 52'd0});
    e = (f[30:23] == 0) ? 1 : int'(f[30:23]);
    mag = real'({f[30:23] != 0, f[22:0]}) * pow2(e - 150);
    return f[31] ? -mag : mag;
  endfunction

  // Rounds a double holding an exact or once-rounded result to single, nearest even.
  function automatic logic [31:0] to_single(input real x);
    logic [63:0] q;
    logic [63:0] sig;
    logic [63:0] kept;
    int fe;
    int sh;
    logic rb;
    logic sticky;
    q = $realtobits(x);
    if (q[62:52] == 11'h7FF) return {q[63], 8'hFF, 23'd0};
    if (q[62:0] == 0) return {q[63], 31'd0};
    sig = {11'd0, 1'b1, q[51:0]};
    fe = int'(q[62:52]) - 1023 + 127;
    sh = (fe >= 1) ? 29 : 29 + 1 - fe;
    if (sh >= 54) return {q[63], 31'd0};
    kept = sig >> sh;
    rb = sig[sh-1];
    sticky = |(sig & ((64'd1 << (sh - 1)) - 1));
    kept = kept + (rb & (sticky | kept[0]));
    if (fe < 1) return {q[63], 31'(kept)};
    if (kept == (64'd1 << 24)) begin
      kept = kept >> 1;
      fe++;
    end
    if (fe >= 255) return {q[63], 8'hFF, 23'd0};
    return {q[63], 8'(fe), kept[22:0]};
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    real s;
    if (fnan(a)) return a | QNAN_BIT;
    if (fnan(b)) return b | QNAN_BIT;
    if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000 && a[31] != b[31])
      return F_DEFAULT_NAN;
    if (a[30:0] == 31'h7F80_0000) return a;
    if (b[30:0] == 31'h7F80_0000) return b;
    s = to_real(a) + to_real(b);
    if (s == 0.0) return {a[31] & b[31], 31'd0};
    return to_single(s);
  endfunction

  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    if (fnan(a)) return a | QNAN_BIT;
    if (fnan(b)) return b | QNAN_BIT;
    return fadd(a, b ^ SIGN_MASK);
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic sg;
    logic az;
    logic bz;
    logic ai;
    logic bi;
    sg = a[31] ^ b[31];
    az = a[30:0] == 0;
    bz = b[30:0] == 0;
    ai = a[30:0] == 31'h7F80_0000;
    bi = b[30:0] == 31'h7F80_0000;
    if (fnan(a)) return a | QNAN_BIT;
    if (fnan(b)) return b | QNAN_BIT;
    if ((ai && bz) || (az && bi)) return F_DEFAULT_NAN;
    if (ai || bi) return {sg, 8'hFF, 23'd0};
    if (az || bz) return {sg, 31'd0};
    return to_single(to_real(a) * to_real(b));
  endfunction

  function automatic logic below(input logic [31:0] a, input logic [31:0] b);
    if (fnan(a) || fnan(b)) return 1'b0;
    return to_real(a) < to_real(b);
  endfunction

  function automatic logic [31:0] ftz(input logic [31:0] x);
    return (x[30:23] == 0) ? {x[31], 31'd0} : x;
  endfunction

  function automatic pair_t gate_sample(input item_t it);
    int unsigned n;
    logic b;
    logic [31:0] d;
    logic [31:0] inc;
    logic [31:0] cnt;
    logic [31:0] cur;
    logic [31:0] thr;
    logic [31:0] pk;
    logic [31:0] gn;
    logic [31:0] g;
    pair_t res;
    b = it.band;
    n = (it.len > BLOCK_MAX) ? BLOCK_MAX : it.len;
    if (it.start) begin
      d = fsub(it.target, ramp_lvl[b]);
      if (below(d, F_SNAP) && below(F_SNAP_NEG, d)) begin
        shared_count = 0;
        ramp_step[b] = 32'd0;
        ramp_lvl[b] = it.target;
      end else if (shared_count != 0) begin
        shared_count = shared_count + n;
      end else begin
        if (below(d, F_SMALL) && below(F_SMALL_NEG, d)) begin
          inc = fmul(d, F_SMALL);
          cnt = to_single(real'(n));
        end else begin
          inc = fmul(d, F_STEP);
          cnt = F_SPAN;
        end
        ramp_step[b] = inc;
        ramp_lvl[b] = fsub(it.target, fmul(inc, cnt));
        shared_count = n;
      end
    end
    cur = fadd(ramp_lvl[b], ramp_step[b]);
    ramp_lvl[b] = cur;
    thr = fmul(cur, gate_cfg[b]);
    pk = peak_lvl[b];
    gn = gain_lvl[b];
    if (below(pk, it.detect)) pk = fadd(pk, fmul(fsub(it.detect, pk), gate_cfg[CFG_PEAK_ATT]));
    else pk = fmul(pk, gate_cfg[CFG_PEAK_REL]);
    if (below(thr, pk)) begin
      gn = fsub(fadd(gate_cfg[CFG_GAIN_ATT_A + b], gn), fmul(gn, gate_cfg[CFG_GAIN_ATT_A + b]));
    end else begin
      gn = fmul(gn, gate_cfg[CFG_GAIN_REL_A + b]);
    end
    g = ftz(gn);
    res.left = ftz(fmul(ftz(it.left), g));
    res.right = ftz(fmul(ftz(it.right), g));
    if (it.fin) begin
      if (below(pk, F_TINY)) pk = 32'd0;
      if (below(gn, F_TINY)) gn = 32'd0;
    end
    peak_lvl[b] = pk;
    gain_lvl[b] = gn;
    return res;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] odd [8];
    odd = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
      32'hFFA0_0000, 32'h0000_0001, 32'h7F7F_FFFF};
    case ($urandom_range(19))
      0, 1: return $urandom;
      2: return odd[$urandom_range(7)];
      default: return {1'($urandom), 8'(127 - $urandom_range(24)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_sample(input item_t it);
    while (!steady && $urandom_range(99) < 13) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    {band, block_start, block_end, block_length} <= {it.band, it.start, it.fin, it.len};
    {target_level, detect_level, left_in, right_in} <= {it.target, it.detect, it.left, it.right};
    do @(posedge clk); while (sample_stall);
    gated_q.push_back(gate_sample(it));
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (gated_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    gate_cfg[idx] = val;
  endtask

  task automatic load_regs(input logic [31:0] v [NUM_CFG]);
    drain();
    for (int i = 0; i < NUM_CFG; i++) write_reg(CFG_IDX_W'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    item_t it;
    item_t list [$];
    it = '{band: 0, start: 1, fin: 0, len: 7'd16, target: 32'd0, detect: ONE,
      left: ONE, right: 32'hBF80_0000};
    list.push_back(it);
    it.target = 32'h3C23_D70A;
    list.push_back(it);
    it.band = 1;
    it.target = 32'h3F00_0000;
    list.push_back(it);
    it.start = 0;
    it.detect = 32'h7F7F_FFFF;
    it.left = 32'h0000_0001;
    it.right = 32'h7F80_0000;
    list.push_back(it);
    it.start = 1;
    it.len = 7'd0;
    it.target = 32'h7FC0_0000;
    list.push_back(it);
    it.band = 0;
    it.len = 7'd127;
    it.target = 32'h3F80_0000;
    it.fin = 1;
    list.push_back(it);
    it.len = 7'd64;
    it.detect = 32'h0;
    it.left = 32'hFFFF_FFFF;
    it.right = 32'h8000_0000;
    list.push_back(it);
    it.start = 0;
    it.fin = 0;
    it.detect = 32'hFF80_0000;
    it.left = 32'h7F7F_FFFF;
    it.right = 32'h0080_0000;
    list.push_back(it);
    it.len = 7'd1;
    it.fin = 1;
    list.push_back(it);
    it.band = 1;
    it.start = 1;
    it.target = 32'h3F00_0001;
    list.push_back(it);
    foreach (list[i]) send_sample(list[i]);
  endtask

  task automatic test_random_blocks(input int count);
    item_t it;
    logic [31:0] last_tgt [2];
    int left_in_blk [2];
    last_tgt = '{32'd0, 32'd0};
    left_in_blk = '{0, 0};
    for (int i = 0; i < count; i++) begin
      it.band = 1'($urandom);
      it.left = rand_float();
      it.right = rand_float();
      it.detect = rand_float();
      if ($urandom_range(9) == 0) begin
        it.start = 1'($urandom);
        it.fin = 1'($urandom);
        it.len = 7'($urandom);
        it.target = $urandom;
      end else begin
        it.start = left_in_blk[it.band] == 0;
        if (it.start) left_in_blk[it.band] = $urandom_range(6, 1);
        case ($urandom_range(3))
          0: it.target = last_tgt[it.band];
          1: it.target = last_tgt[it.band] + $urandom_range(300);
          default: it.target = {1'($urandom_range(7) == 0), 8'(126 - $urandom_range(10)),
            23'($urandom)};
        endcase
        it.len = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(64, 1));
        left_in_blk[it.band]--;
        it.fin = left_in_blk[it.band] == 0;
      end
      if (it.start) last_tgt[it.band] = it.target;
      send_sample(it);
    end
  endtask

  task automatic test_settings();
    logic [31:0] v [NUM_CFG];
    v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    load_regs(v);
    test_random_blocks(120);
    v = '{32'hFFFF_FFFF, 32'h7F80_0000, ONE, ONE, ONE, ONE, ONE, ONE};
    load_regs(v);
    test_random_blocks(120);
    for (int k = 0; k < 4; k++) begin
      foreach (v[i]) v[i] = (k == 0) ? $urandom :
        {1'b0, 8'(126 - $urandom_range(12)), 23'($urandom)};
      load_regs(v);
      test_random_blocks(250);
    end
    load_regs(CFG_RESET);
  endtask

  always @(posedge clk) begin
    pair_t want;
    if (!rst && result_valid && !result_stall) begin
      if (gated_q.size() == 0) begin
        $display("%0t unexpected result left %h right %h", $time, left_out, right_out);
        failed = 1'b1;
      end else begin
        want = gated_q.pop_front();
        if (left_out !== want.left) begin
          $display("%0t left_out expected %h actual %h", $time, want.left, left_out);
          failed = 1'b1;
        end
        if (right_out !== want.right) begin
          $display("%0t right_out expected %h actual %h", $time, want.right, right_out);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_stall <= !steady && ($urandom_range(99) < 13);
  end

  initial begin
    #40_000_000;
    $display("[gated_gain_envelope_top] ERROR");
    $finish;
  end

  initial begin
    failed = 1'b0;
    steady = 1'b0;
    rst = 1'b1;
    sample_valid = 1'b0;
    result_stall = 1'b0;
    {band, block_start, block_end, block_length} = '0;
    {target_level, detect_level, left_in, right_in} = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (gate_cfg[i]) gate_cfg[i] = CFG_RESET[i];
    ramp_lvl = '{32'd0, 32'd0};
    ramp_step = '{32'd0, 32'd0};
    peak_lvl = '{32'd0, 32'd0};
    gain_lvl = '{32'd0, 32'd0};
    shared_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_blocks(300);
    steady = 1'b1;
    test_random_blocks(200);
    steady = 1'b0;
    test_settings();
    test_random_blocks(100);
    drain();
    if (!failed) $display("[gated_gain_envelope_top] OK");
    else $display("[gated_gain_envelope_top] ERROR");
    $finish;
  end

endmodule
